// ----- rtl/mfc_pkg.sv -----
// Meter frame checker package: constants, codes, queue item type and CRC step.
// Used by every module of the block; depends on nothing.
package mfc_pkg;

  localparam int FIXED_HEADER_BYTES = 5;
  localparam logic [15:0] HDR_FIXED = 16'(FIXED_HEADER_BYTES);

  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_XOR   = 16'hFFFF;
  localparam logic [15:0] CRC_RESET = 16'hFFFF;
  localparam logic [15:0] IDX_MAX   = 16'hFFFF;

  localparam logic [15:0] RST_CRC_PRESET = 16'hFFFF;
  localparam logic [7:0]  RST_MIN_FRAME  = 8'd12;
  localparam logic [7:0]  RST_START_BYTE = 8'h68;
  localparam logic [7:0]  RST_END_BYTE   = 8'h16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_OK, ST_SHORT, ST_LEN, ST_START, ST_END, ST_HCRC, ST_FCRC
  } status_t;

  typedef enum logic [1:0] {
    REG_CRC_PRESET, REG_MIN_FRAME, REG_START_BYTE, REG_END_BYTE
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] crc_preset;
    logic [7:0]  min_frame_bytes;
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
  } mfc_cfg_t;

  // one classified word on its way from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic        crc_en;
    logic        hdr_snap;
    logic        hdr_chk;
    logic        frm_chk;
    logic        low_store;
    logic        bad_start;
    logic        too_short;
    logic        len_mismatch;
    logic        direction;
    logic [15:0] frame_bytes;
  } mfc_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

// ----- rtl/mfc_if.sv -----
// Channel interfaces of the meter frame checker: byte input, result output, register writes.
// Depends on nothing.
interface mfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, data_byte, is_last, input ready);
  modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface mfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        direction;
  logic [15:0] frame_bytes;
  modport source (output valid, status, direction, frame_bytes, input ready);
  modport sink   (input valid, status, direction, frame_bytes, output ready);
endinterface

interface mfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mfc_front.sv -----
// Front end: accepts bytes, tracks position, length and address length, and
// tags each word with the CRC actions and frame checks due. Depends on mfc_pkg and mfc_if.
module mfc_front
  import mfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mfc_in_if.sink    in,
  input  mfc_cfg_t  cfg_regs,
  input  logic      full,
  output logic      push,
  output mfc_item_t item
);

  logic [15:0] byte_index;
  logic [15:0] length_field;
  logic [4:0]  addr_bytes;
  logic        dir_bit;

  logic [15:0] length_next;
  logic [4:0]  addr_next;
  logic        dir_next;
  logic [15:0] hdr_end;
  logic [15:0] frm_end;
  logic [15:0] count;
  logic        len_ok;
  logic        hdr_valid;
  logic [7:0]  b;

  assign b        = in.data_byte;
  assign in.ready = !full;
  assign push     = in.valid && !full;

  always_comb begin
    length_next = length_field;
    addr_next   = addr_bytes;
    dir_next    = dir_bit;
    if (byte_index == 16'd1) length_next = {length_field[15:8], b};
    if (byte_index == 16'd2) length_next = {b, length_field[7:0]};
    if (byte_index == 16'd3) dir_next = b[7];
    if (byte_index == 16'd4) addr_next = {1'b0, b[3:0]} + 5'd1;

    len_ok    = length_next >= 16'd3;
    frm_end   = length_next - 16'd2;
    hdr_end   = HDR_FIXED + {11'd0, addr_next};
    hdr_valid = byte_index >= 16'd5 && hdr_end >= 16'd5 && len_ok && hdr_end <= frm_end;
    count     = (byte_index == IDX_MAX) ? IDX_MAX : byte_index + 16'd1;

    item.data_byte    = b;
    item.last         = in.is_last;
    item.crc_en       = byte_index >= 16'd1 &&
                        (byte_index <= 16'd2 || (len_ok && byte_index <= frm_end));
    item.hdr_snap     = hdr_valid && byte_index == hdr_end;
    item.hdr_chk      = hdr_valid && byte_index == hdr_end + 16'd2;
    item.frm_chk      = len_ok && byte_index >= 16'd3 && byte_index == length_next;
    item.low_store    = (hdr_valid && byte_index == hdr_end + 16'd1) ||
                        (len_ok && byte_index == length_next - 16'd1);
    item.bad_start    = byte_index == 16'd0 && b != cfg_regs.start_byte;
    item.frame_bytes  = length_next + 16'd2;
    item.too_short    = count < {8'd0, cfg_regs.min_frame_bytes};
    item.len_mismatch = count != item.frame_bytes;
    item.direction    = dir_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      length_field <= '0;
      addr_bytes   <= '0;
      dir_bit      <= 1'b0;
    end else if (push) begin
      if (in.is_last) begin
        byte_index   <= '0;
        length_field <= '0;
        addr_bytes   <= '0;
        dir_bit      <= 1'b0;
      end else begin
        if (byte_index != IDX_MAX) byte_index <= byte_index + 16'd1;
        length_field <= length_next;
        addr_bytes   <= addr_next;
        dir_bit      <= dir_next;
      end
    end
  end

endmodule

// ----- rtl/mfc_queue.sv -----
// Short queue of classified words between front and back end.
// Depends on mfc_pkg.
module mfc_queue
  import mfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mfc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      nonempty,
  output mfc_item_t pop_item
);

  mfc_item_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     fill;

  assign full     = fill == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign nonempty = fill != '0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/mfc_back.sv -----
// Back end: runs the CRC, checks header and frame CRC, keeps the flags and
// registers the status word. Depends on mfc_pkg and mfc_if.
module mfc_back
  import mfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mfc_cfg_t  cfg_regs,
  input  logic      q_valid,
  input  mfc_item_t item,
  output logic      pop,
  mfc_out_if.source out
);

  logic [15:0] crc_reg;
  logic [15:0] header_crc_snapshot;
  logic [7:0]  stored_low_byte;
  logic        flag_bad_start;
  logic        flag_hdr_ok;
  logic        flag_frm_ok;

  logic [15:0] crc_next;
  logic [15:0] got;
  logic        bad_next;
  logic        hdr_ok_next;
  logic        frm_ok_next;
  status_t     status_next;

  assign pop = q_valid && (!item.last || !out.valid || out.ready);

  always_comb begin
    crc_next    = item.crc_en ? crc_byte(crc_reg, item.data_byte) : crc_reg;
    got         = {item.data_byte, stored_low_byte};
    bad_next    = flag_bad_start | item.bad_start;
    hdr_ok_next = item.hdr_chk ? (got == header_crc_snapshot) : flag_hdr_ok;
    frm_ok_next = item.frm_chk ? (got == (crc_next ^ CRC_XOR)) : flag_frm_ok;
    priority if (item.too_short)                       status_next = ST_SHORT;
    else if (item.len_mismatch)                        status_next = ST_LEN;
    else if (bad_next)                                 status_next = ST_START;
    else if (item.data_byte != cfg_regs.end_byte)      status_next = ST_END;
    else if (!hdr_ok_next)                             status_next = ST_HCRC;
    else if (!frm_ok_next)                             status_next = ST_FCRC;
    else                                               status_next = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg             <= CRC_RESET;
      header_crc_snapshot <= '0;
      stored_low_byte     <= '0;
      flag_bad_start      <= 1'b0;
      flag_hdr_ok         <= 1'b0;
      flag_frm_ok         <= 1'b0;
    end else if (pop) begin
      if (item.last) begin
        crc_reg             <= cfg_regs.crc_preset;
        header_crc_snapshot <= '0;
        stored_low_byte     <= '0;
        flag_bad_start      <= 1'b0;
        flag_hdr_ok         <= 1'b0;
        flag_frm_ok         <= 1'b0;
      end else begin
        crc_reg        <= crc_next;
        flag_bad_start <= bad_next;
        flag_hdr_ok    <= hdr_ok_next;
        flag_frm_ok    <= frm_ok_next;
        if (item.hdr_snap)  header_crc_snapshot <= crc_next ^ CRC_XOR;
        if (item.low_store) stored_low_byte <= item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      if (pop && item.last)       out.valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      out.status      <= status_next;
      out.direction   <= item.direction;
      out.frame_bytes <= item.frame_bytes;
    end
  end

endmodule

// ----- rtl/meter_frame_checker.sv -----
// Top level of the meter frame checker: register file, front end, queue, back end.
// Depends on mfc_pkg, mfc_if, mfc_front, mfc_queue and mfc_back.
//
// Usage: bytes of one candidate frame enter on the in channel, one word per
// byte, the final byte flagged by is_last. For each frame one result word
// leaves on the out channel: status, direction bit and length field plus two.
// Registers (CRC preset, minimum length, start and end byte) are written on
// the cfg channel, which is always ready; write them between frames only.
// Throughput: one byte per cycle while in.ready is high. A byte is classified by
// the front end in the cycle it is accepted and is checked the cycle it leaves
// the two-word queue; the result word is registered in the output register when
// the last byte leaves the queue. When the receiver stalls, the result waits in
// the output register while bytes of the next frame keep flowing until the queue
// is full with the next frame end at its head, then in.ready drops. Reset clears
// frame state and queue and restores register defaults; a CRC preset written is
// loaded at the next frame end, so it applies from the frame after that one.
module meter_frame_checker
  import mfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mfc_in_if.sink     in,
  mfc_out_if.source  out,
  mfc_cfg_if.sink    cfg
);

  mfc_cfg_t  cfg_regs;
  mfc_item_t front_item;
  mfc_item_t back_item;
  logic      push;
  logic      full;
  logic      pop;
  logic      nonempty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.crc_preset      <= RST_CRC_PRESET;
      cfg_regs.min_frame_bytes <= RST_MIN_FRAME;
      cfg_regs.start_byte      <= RST_START_BYTE;
      cfg_regs.end_byte        <= RST_END_BYTE;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_CRC_PRESET: cfg_regs.crc_preset      <= cfg.data;
        REG_MIN_FRAME:  cfg_regs.min_frame_bytes <= cfg.data[7:0];
        REG_START_BYTE: cfg_regs.start_byte      <= cfg.data[7:0];
        REG_END_BYTE:   cfg_regs.end_byte        <= cfg.data[7:0];
        default:        cfg_regs                 <= cfg_regs;
      endcase
    end
  end

  mfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in       (in),
    .cfg_regs (cfg_regs),
    .full     (full),
    .push     (push),
    .item     (front_item)
  );

  mfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_item  (back_item)
  );

  mfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_valid  (nonempty),
    .item     (back_item),
    .pop      (pop),
    .out      (out)
  );

endmodule

// ----- tb/tb_meter_frame_checker.sv -----
// Testbench for meter_frame_checker: directed and random frames, register settings,
// idle/stall phases and back-pressure, checked against a built-in frame predictor.
// Depends on mfc_pkg, mfc_if and the meter_frame_checker RTL.
module tb_meter_frame_checker
  import mfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT  = 1_000_000;
  localparam int SETTLE = 8;
  localparam int HOLD   = 300;

  typedef struct {
    status_t     st;
    logic        dir;
    logic [15:0] fb;
  } verdict_t;

  class frame_verdict_predictor;
    logic [15:0] preset_r;
    logic [7:0]  min_r, start_r, end_r;
    logic [15:0] idx, crc, len_fld, hdr_snap;
    logic [4:0]  addr_n;
    logic [7:0]  low_b;
    logic [3:0]  flags;
    logic        dir_b;
    verdict_t    expected_verdicts[$];
    int          errors;

    function new();
      preset_r = RST_CRC_PRESET;
      min_r    = RST_MIN_FRAME;
      start_r  = RST_START_BYTE;
      end_r    = RST_END_BYTE;
      errors   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      idx = '0; crc = preset_r; len_fld = '0; addr_n = '0;
      hdr_snap = '0; low_b = '0; flags = '0; dir_b = 1'b0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fbk;
      r = c;
      for (int k = 0; k < 8; k++) begin
        fbk = r[0] ^ b[k];
        r = {1'b0, r[15:1]};
        if (fbk) r = r ^ 16'h8408;
      end
      return r;
    endfunction

    function void write_reg(cfg_reg_t r, logic [15:0] v);
      case (r)
        REG_CRC_PRESET: preset_r = v;
        REG_MIN_FRAME:  min_r = v[7:0];
        REG_START_BYTE: start_r = v[7:0];
        REG_END_BYTE:   end_r = v[7:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [15:0] i, hdr_end, frm_end, got, n, fb;
      logic        len_ok, hdr_ok;
      verdict_t    v;
      i = idx;
      if (i == 16'd0 && b != start_r) flags[0] = 1'b1;
      if (i == 16'd1) len_fld[7:0] = b;
      if (i == 16'd2) len_fld[15:8] = b;
      if (i == 16'd3) dir_b = b[7];
      if (i == 16'd4) addr_n = {1'b0, b[3:0]} + 5'd1;
      len_ok  = len_fld >= 16'd3;
      frm_end = len_fld - 16'd2;
      hdr_end = 16'(FIXED_HEADER_BYTES) + 16'(addr_n);
      hdr_ok  = i >= 16'd5 && hdr_end >= 16'd5 && len_ok && hdr_end <= frm_end;
      if (i >= 16'd1 && (i <= 16'd2 || (len_ok && i <= frm_end))) crc = crc_step(crc, b);
      if (hdr_ok && i == hdr_end) hdr_snap = crc ^ 16'hFFFF;
      got = {b, low_b};
      if (hdr_ok && i == 16'(hdr_end + 16'd2)) flags[1] = (got == hdr_snap);
      if (len_ok && i >= 16'd3 && i == len_fld) flags[2] = (got == (crc ^ 16'hFFFF));
      if ((hdr_ok && i == 16'(hdr_end + 16'd1)) || (len_ok && i == 16'(len_fld - 16'd1)))
        low_b = b;
      if (idx != 16'hFFFF) idx = idx + 16'd1;
      if (!last) return;
      n  = (i == 16'hFFFF) ? 16'hFFFF : i + 16'd1;
      fb = len_fld + 16'd2;
      if (n < {8'h00, min_r})  v.st = ST_SHORT;
      else if (n != fb)        v.st = ST_LEN;
      else if (flags[0])       v.st = ST_START;
      else if (b != end_r)     v.st = ST_END;
      else if (!flags[1])      v.st = ST_HCRC;
      else if (!flags[2])      v.st = ST_FCRC;
      else                     v.st = ST_OK;
      v.dir = dir_b;
      v.fb  = fb;
      expected_verdicts.push_back(v);
      clear_frame();
    endfunction

    function void check_result(logic [2:0] st, logic dir, logic [15:0] fb);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with none expected: status %0d dir %0d bytes %0d",
                 $time, st, dir, fb);
        errors++;
        return;
      end
      v = expected_verdicts.pop_front();
      if (st !== v.st) begin
        $display("%0t: status expected %0d, got %0d", $time, v.st, st);
        errors++;
      end
      if (dir !== v.dir) begin
        $display("%0t: direction expected %0d, got %0d", $time, v.dir, dir);
        errors++;
      end
      if (fb !== v.fb) begin
        $display("%0t: frame_bytes expected %0d, got %0d", $time, v.fb, fb);
        errors++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic clk, rst;
  mfc_in_if  in_ch();
  mfc_out_if res_ch();
  mfc_cfg_if cfg_ch();

  meter_frame_checker DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (res_ch),
    .cfg (cfg_ch)
  );

  frame_verdict_predictor verdict;
  logic [7:0]  frame_q[$];
  int unsigned bytes_sent = 0;
  int          src_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      verdict.check_result(res_ch.status, res_ch.direction, res_ch.frame_bytes);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    verdict.take_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (verdict.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    verdict.write_reg(r, v);
  endtask

  task automatic load_regs(input logic [15:0] preset, input logic [7:0] min_b,
                           input logic [7:0] st_b, input logic [7:0] end_b);
    wait_idle();
    put_reg(REG_CRC_PRESET, preset);
    put_reg(REG_MIN_FRAME, {8'($urandom), min_b});
    put_reg(REG_START_BYTE, {8'($urandom), st_b});
    put_reg(REG_END_BYTE, {8'($urandom), end_b});
    cfg_ch.valid <= 1'b0;
  endtask

  // well-formed frame of length field len_f, with the CRC fields filled in where the frame holds them
  task automatic build_good(input int unsigned len_f, input int unsigned nib);
    int          hdr_end;
    logic [15:0] c;
    frame_q.delete();
    repeat (len_f + 2) frame_q.push_back(8'($urandom));
    frame_q[0] = verdict.start_r;
    frame_q[1] = len_f[7:0];
    if (frame_q.size() > 2) frame_q[2] = len_f[15:8];
    if (frame_q.size() > 4) frame_q[4] = {frame_q[4][7:4], nib[3:0]};
    hdr_end = FIXED_HEADER_BYTES + nib + 1;
    if (hdr_end + 2 < frame_q.size()) begin
      c = verdict.crc;
      for (int k = 1; k <= hdr_end; k++) c = verdict.crc_step(c, frame_q[k]);
      c = c ^ 16'hFFFF;
      frame_q[hdr_end + 1] = c[7:0];
      frame_q[hdr_end + 2] = c[15:8];
    end
    if (len_f >= 3) begin
      c = verdict.crc;
      for (int k = 1; k <= len_f - 2; k++) c = verdict.crc_step(c, frame_q[k]);
      c = c ^ 16'hFFFF;
      frame_q[len_f - 1] = c[7:0];
      frame_q[len_f]     = c[15:8];
    end
    frame_q[len_f + 1] = verdict.end_r;
  endtask

  task automatic build_noise(input int unsigned n);
    frame_q.delete();
    repeat (n) frame_q.push_back(8'($urandom));
    if ($urandom_range(1)) frame_q[0] = verdict.start_r;
    if (n > 2 && $urandom_range(1)) begin
      frame_q[1] = 8'(n - 2);
      frame_q[2] = 8'h00;
    end
    if ($urandom_range(1)) frame_q[n - 1] = verdict.end_r;
  endtask

  task automatic directed_frames();
    build_good(12, 0);  send_frame();
    build_good(25, 15); send_frame();
    build_good(14, 1);  frame_q[0]  ^= 8'h01; send_frame();
    build_good(14, 1);  frame_q[15] ^= 8'h80; send_frame();
    build_good(16, 1);  frame_q[8]  ^= 8'h04; send_frame();
    build_good(16, 1);  frame_q[11] ^= 8'h10; send_frame();
    build_noise(3);     send_frame();
    build_good(12, 0);  frame_q.insert(13, 8'h5A); send_frame();
    // length field plus two wraps past 16 bits
    build_noise(13); frame_q[1] = 8'hFF; frame_q[2] = 8'hFF; send_frame();
    build_noise(13); frame_q[1] = 8'hFE; frame_q[2] = 8'hFF; send_frame();

    load_regs(16'hFFFF, 8'd0, RST_START_BYTE, RST_END_BYTE);
    build_good(2, 0);   send_frame();
    build_good(1, 0);   send_frame();
    build_good(0, 0);   send_frame();
    frame_q.delete(); frame_q.push_back(verdict.start_r); send_frame();
    build_good(20, 15); send_frame();   // header runs past the frame CRC
    build_good(11, 3);  send_frame();   // both CRC fields at the same bytes
    build_good(12, 3);  send_frame();   // CRC fields share one byte

    load_regs(16'hFFFF, 8'd255, RST_START_BYTE, RST_END_BYTE);
    build_good(253, 2); send_frame();
    build_good(252, 2); send_frame();
  endtask

  task automatic random_frames(input int unsigned byte_goal);
    int unsigned start_cnt, nib, h, len_f, pick;
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < byte_goal) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        build_noise($urandom_range(1, 24));
      end else begin
        nib = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
        h = FIXED_HEADER_BYTES + nib + 1;
        if ($urandom_range(9) == 0) len_f = h + $urandom_range(3);
        else len_f = h + 4 + $urandom_range(14);
        build_good(len_f, nib);
        if (pick < 25) frame_q[$urandom_range(frame_q.size() - 1)] ^= 8'($urandom_range(1, 255));
        else if (pick < 30) frame_q.insert(frame_q.size() - 1, 8'($urandom));
        else if (pick < 35) frame_q.delete(frame_q.size() - 2);
      end
      send_frame();
    end
  endtask

  task automatic pressure_burst();
    hold_reqs++;
    repeat (8) begin
      build_noise($urandom_range(1, 3));
      send_frame();
    end
  endtask

  initial begin
    int          k;
    logic [15:0] preset;
    logic [7:0]  st_b, end_b, min_b;
    verdict = new();
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.is_last   <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_CRC_PRESET;
    cfg_ch.data     <= 16'h0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_frames();

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        k = p * 2 + s;
        preset = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
        st_b   = (k == 2) ? 8'h00 : (k == 3) ? 8'hFF : 8'($urandom);
        end_b  = (k == 2) ? 8'hFF : (k == 3) ? 8'h00 : 8'($urandom);
        min_b  = (k == 4) ? 8'd0 : 8'($urandom_range(20));
        load_regs(preset, min_b, st_b, end_b);
        case (p)
          0: begin src_idle_pct = 0;  stall_pct = 0;  end
          1: begin src_idle_pct = 83; stall_pct = 0;  end
          2: begin src_idle_pct = 0;  stall_pct = 83; end
          default: begin src_idle_pct = 15; stall_pct = 15; end
        endcase
        if (k == 0) pressure_burst();
        random_frames(40);
      end
    end

    wait_idle();
    if (verdict.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
